@@ sv/joint_pd_torque_controller_core_defines.svh @@
// Assertion macros shared by the joint PD controller modules.
`ifndef JOINT_PD_TORQUE_CONTROLLER_CORE_DEFINES_SVH
`define JOINT_PD_TORQUE_CONTROLLER_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define JPD_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Implication whose right side is checked in the cycle after the left side holds.
`define JPD_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

@@ sv/jpdtc_pkg.sv @@
// Shared types, constants and tables for the joint PD controller.
package jpdtc_pkg;
   localparam int NumJointsDefault = 16;
   localparam logic [1:0] ACT_SAMPLE   = 2'd0;
   localparam logic [1:0] ACT_TARGET   = 2'd1;
   localparam logic [1:0] ACT_SETTINGS = 2'd2;
   localparam logic [1:0] ACT_MODE     = 2'd3;
   localparam logic [1:0] CMD_ON   = 2'd0;
   localparam logic [1:0] CMD_HOME = 2'd1;
   localparam logic [1:0] CMD_OFF  = 2'd2;
   localparam logic [1:0] CMD_SAVE = 2'd3;
   localparam logic [16:0] W_OLD = 17'd39322;
   localparam logic [16:0] W_RAW = 17'd12976;
   localparam logic [15:0] TGR_RESET = 16'hFFFF;

   // Datapath operation selected by the controller
   localparam logic [3:0] OP_NONE   = 4'd0;
   localparam logic [3:0] OP_LOAD   = 4'd1;
   localparam logic [3:0] OP_PF     = 4'd2;
   localparam logic [3:0] OP_DVEL   = 4'd3;
   localparam logic [3:0] OP_DRAW   = 4'd4;
   localparam logic [3:0] OP_DIVSTEP= 4'd5;
   localparam logic [3:0] OP_VEL    = 4'd6;
   localparam logic [3:0] OP_RV     = 4'd7;
   localparam logic [3:0] OP_VF     = 4'd8;
   localparam logic [3:0] OP_PTERM  = 4'd9;
   localparam logic [3:0] OP_DTERM  = 4'd10;
   localparam logic [3:0] OP_TMUL   = 4'd11;
   localparam logic [3:0] OP_TORQ   = 4'd12;
   localparam logic [3:0] OP_STORE  = 4'd13;

   typedef struct packed {
      logic [3:0] op;
      logic       sel_raw;   // divider works on raw difference
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

   function automatic logic [15:0] kp_default(input logic [3:0] j);
      case (j)
         4'd3, 4'd7, 4'd11, 4'd12, 4'd13, 4'd14: kp_default = 16'd16000;
         default: kp_default = 16'd9600;
      endcase
   endfunction

   function automatic logic [15:0] kd_default(input logic [3:0] j);
      case (j)
         4'd1, 4'd5, 4'd9, 4'd13, 4'd14: kd_default = 16'd320;
         4'd12: kd_default = 16'd480;
         default: kd_default = 16'd240;
      endcase
   endfunction

   function automatic logic signed [23:0] home_default(input logic [3:0] j);
      case (j)
         4'd1, 4'd5: home_default = -24'sd183011;
         4'd2, 4'd3, 4'd6, 4'd7, 4'd11, 4'd15: home_default = 24'sd823550;
         4'd8: home_default = 24'sd91506;
         4'd9: home_default = -24'sd91506;
         4'd10: home_default = 24'sd915055;
         4'd12: home_default = 24'sd1098066;
         4'd13: home_default = 24'sd457528;
         4'd14: home_default = 24'sd274517;
         default: home_default = 24'sd0;
      endcase
   endfunction
endpackage

@@ sv/jpdtc_ctrl.sv @@
// Controller state machine sequencing one sample word through the datapath.
module jpdtc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,      // sample word accepted
   input  jpdtc_pkg::status_type  status,
   output jpdtc_pkg::cmd_type     cmd,
   output logic                   busy,
   output logic                   done
);
   localparam logic [3:0] S_IDLE = 4'd0, S_PF = 4'd1, S_DV = 4'd2, S_DIV = 4'd3,
      S_VEL = 4'd4, S_DR = 4'd5, S_DIV2 = 4'd6, S_RV = 4'd7, S_VF = 4'd8,
      S_PT = 4'd9, S_DT = 4'd10, S_TM = 4'd11, S_TQ = 4'd12, S_ST = 4'd13;
   logic [3:0] state_ff, state_in;

   // Advance through the fixed schedule; divider states wait on done
   always_comb begin
      state_in = state_ff;
      cmd = '{op: jpdtc_pkg::OP_NONE, sel_raw: 1'b0};
      done = 1'b0;
      case (state_ff)
         S_IDLE: if (start) state_in = S_PF;
         S_PF: begin cmd.op = jpdtc_pkg::OP_PF; state_in = S_DV; end
         S_DV: begin cmd.op = jpdtc_pkg::OP_DVEL; state_in = S_DIV; end
         S_DIV: begin
            cmd.op = jpdtc_pkg::OP_DIVSTEP;
            if (status.div_done) state_in = S_VEL;
         end
         S_VEL: begin cmd.op = jpdtc_pkg::OP_VEL; state_in = S_DR; end
         S_DR: begin cmd.op = jpdtc_pkg::OP_DRAW; cmd.sel_raw = 1'b1; state_in = S_DIV2; end
         S_DIV2: begin
            cmd.op = jpdtc_pkg::OP_DIVSTEP; cmd.sel_raw = 1'b1;
            if (status.div_done) state_in = S_RV;
         end
         S_RV: begin cmd.op = jpdtc_pkg::OP_RV; state_in = S_VF; end
         S_VF: begin cmd.op = jpdtc_pkg::OP_VF; state_in = S_PT; end
         S_PT: begin cmd.op = jpdtc_pkg::OP_PTERM; state_in = S_DT; end
         S_DT: begin cmd.op = jpdtc_pkg::OP_DTERM; state_in = S_TM; end
         S_TM: begin cmd.op = jpdtc_pkg::OP_TMUL; state_in = S_TQ; end
         S_TQ: begin cmd.op = jpdtc_pkg::OP_TORQ; state_in = S_ST; end
         S_ST: begin cmd.op = jpdtc_pkg::OP_STORE; done = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);
endmodule

@@ sv/jpdtc_datapath.sv @@
// Per-joint state, filter, divider and torque arithmetic.
`include "joint_pd_torque_controller_core_defines.svh"
module jpdtc_datapath #(
   parameter int NUM_JOINTS = jpdtc_pkg::NumJointsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  jpdtc_pkg::cmd_type    cmd,
   output jpdtc_pkg::status_type status,
   input  logic                  in_take,       // word accepted this cycle
   input  logic [1:0]            in_action,
   input  logic [3:0]            in_joint,
   input  logic signed [23:0]    in_raw,
   input  logic [15:0]           in_dt,
   input  logic signed [23:0]    in_target,
   input  logic [15:0]           in_kp,
   input  logic [15:0]           in_kd,
   input  logic signed [23:0]    in_home,
   input  logic [1:0]            in_cmd,
   input  logic [15:0]           tgr,
   output logic [3:0]            o_joint,
   output logic signed [15:0]    o_torque,
   output logic signed [23:0]    o_pos,
   output logic signed [31:0]    o_vel,
   output logic                  o_clip,
   output logic                  o_pd
);
   localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
   localparam int QW = 48;       // quotient magnitude width

   logic signed [23:0] lrp_ff [NUM_JOINTS];
   logic signed [23:0] fp_ff  [NUM_JOINTS];
   logic signed [31:0] lrv_ff [NUM_JOINTS];
   logic signed [31:0] fv_ff  [NUM_JOINTS];
   logic signed [23:0] tgt_ff [NUM_JOINTS];
   logic [15:0]        kp_ff  [NUM_JOINTS];
   logic [15:0]        kd_ff  [NUM_JOINTS];
   logic signed [23:0] home_ff[NUM_JOINTS];
   logic               pd_ff;

   // Working registers of the current sample
   logic [JW-1:0]      j_ff;
   logic signed [23:0] raw_ff, prev_ff, pfold_ff, pf_ff, tg_ff;
   logic signed [31:0] fvold_ff, lrvold_ff, vel_ff, vf_ff;
   logic [15:0]        kp_w_ff, kd_w_ff;
   logic [20:0]        dsor_ff;   // dt*16
   logic               clip_ff;
   logic signed [48:0] pd_ff2;
   logic [63:0]        prod_ff;
   logic signed [15:0] torq_ff;
   // Restoring divider
   logic [QW-1:0]      num_ff, quo_ff;
   logic [21:0]        rem_ff;
   logic [5:0]         cnt_ff;
   logic               neg_ff;

   logic [3:0]         oj_ff;
   logic signed [15:0] ot_ff;
   logic signed [23:0] op_ff;
   logic signed [31:0] ov_ff;
   logic               oc_ff;

   logic [JW-1:0] in_j;
   logic          in_ok;
   assign in_j  = JW'(in_joint);
   assign in_ok = ({3'b0, in_joint} < 7'(NUM_JOINTS));

   // Filter sums, divider inputs, PD terms and torque rounding
   logic signed [63:0] pf_sum, vf_sum, pf_rnd, vf_rnd;
   logic signed [63:0] diff_mul, pterm, dterm, vel_rnd;
   logic [63:0]        pf_mag, vf_mag;
   logic [21:0]        rem_try;
   logic [63:0]        tm_rnd;
   always_comb begin
      pf_sum = $signed({1'b0, jpdtc_pkg::W_OLD}) * 64'(pfold_ff)
             + $signed({1'b0, jpdtc_pkg::W_RAW}) * 64'(prev_ff)
             + $signed({1'b0, jpdtc_pkg::W_RAW}) * 64'(raw_ff);
      pf_mag = pf_sum[63] ? 64'(-pf_sum) : 64'(pf_sum);
      pf_mag = (pf_mag + 64'd32768) >> 16;
      pf_rnd = pf_sum[63] ? -$signed(pf_mag) : $signed(pf_mag);
      vf_sum = $signed({1'b0, jpdtc_pkg::W_OLD}) * 64'(fvold_ff)
             + $signed({1'b0, jpdtc_pkg::W_RAW}) * 64'(lrvold_ff)
             + $signed({1'b0, jpdtc_pkg::W_RAW}) * 64'(vel_ff);
      vf_mag = vf_sum[63] ? 64'(-vf_sum) : 64'(vf_sum);
      vf_mag = (vf_mag + 64'd32768) >> 16;
      vf_rnd = vf_sum[63] ? -$signed(vf_mag) : $signed(vf_mag);
      diff_mul = (cmd.sel_raw ? (64'(raw_ff) - 64'(prev_ff)) : (64'(pf_ff) - 64'(pfold_ff)))
                 * 64'sd1000000;
      rem_try = {rem_ff[20:0], num_ff[QW-1]};
      vel_rnd = neg_ff ? -$signed(64'(quo_ff)) : $signed(64'(quo_ff));
      pterm = $signed({1'b0, kp_w_ff}) * 64'(64'(tg_ff) - 64'(pf_ff));
      dterm = $signed({1'b0, kd_w_ff}) * 64'(vf_ff);
      tm_rnd = (prod_ff + 64'h8_0000_0000) >> 36;
   end

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) sat32 = 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
   endfunction
   function automatic logic ovf32(input logic signed [63:0] v);
      ovf32 = (v > 64'sd2147483647) || (v < -64'sd2147483648);
   endfunction

   logic [63:0] ptm;
   always_comb begin
      ptm = pterm[63] ? 64'(-pterm) : 64'(pterm);
      ptm = (ptm + 64'd8) >> 4;
   end

   assign status.div_done = (cnt_ff == 6'd0);

   // Hold state arrays and mode
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_JOINTS; k++) begin
            lrp_ff[k] <= '0; fp_ff[k] <= '0; lrv_ff[k] <= '0; fv_ff[k] <= '0;
            kp_ff[k] <= jpdtc_pkg::kp_default(4'(k));
            kd_ff[k] <= jpdtc_pkg::kd_default(4'(k));
            home_ff[k] <= jpdtc_pkg::home_default(4'(k));
            tgt_ff[k] <= jpdtc_pkg::home_default(4'(k));
         end
         pd_ff <= 1'b0;
      end else begin
         if (in_take && in_ok && in_action == jpdtc_pkg::ACT_TARGET)
            tgt_ff[in_j] <= in_target;
         if (in_take && in_ok && in_action == jpdtc_pkg::ACT_SETTINGS) begin
            kp_ff[in_j] <= in_kp; kd_ff[in_j] <= in_kd; home_ff[in_j] <= in_home;
         end
         if (in_take && in_action == jpdtc_pkg::ACT_MODE) begin
            case (in_cmd)
               jpdtc_pkg::CMD_ON: pd_ff <= 1'b1;
               jpdtc_pkg::CMD_HOME: begin
                  for (int k = 0; k < NUM_JOINTS; k++) tgt_ff[k] <= home_ff[k];
                  pd_ff <= 1'b1;
               end
               jpdtc_pkg::CMD_OFF: pd_ff <= 1'b0;
               default: for (int k = 0; k < NUM_JOINTS; k++) tgt_ff[k] <= lrp_ff[k];
            endcase
         end
         if (cmd.op == jpdtc_pkg::OP_STORE) begin
            fp_ff[j_ff] <= pf_ff; fv_ff[j_ff] <= vf_ff;
            lrv_ff[j_ff] <= lrvold_ff; lrp_ff[j_ff] <= raw_ff;
         end
      end
   end

   // Advance the sample computation
   always_ff @(posedge clock) begin
      if (in_take) begin
         j_ff <= in_j; raw_ff <= in_raw;
         prev_ff <= lrp_ff[in_j]; pfold_ff <= fp_ff[in_j];
         fvold_ff <= fv_ff[in_j]; lrvold_ff <= lrv_ff[in_j];
         tg_ff <= tgt_ff[in_j]; kp_w_ff <= kp_ff[in_j]; kd_w_ff <= kd_ff[in_j];
         dsor_ff <= {(in_dt == 16'd0) ? 16'd1 : in_dt, 5'd0} >> 1;
         clip_ff <= 1'b0; torq_ff <= '0;
      end
      case (cmd.op)
         jpdtc_pkg::OP_PF: begin
            if (pf_rnd > 64'sd8388607) begin pf_ff <= 24'sh7FFFFF; clip_ff <= 1'b1; end
            else if (pf_rnd < -64'sd8388608) begin pf_ff <= 24'sh800000; clip_ff <= 1'b1; end
            else pf_ff <= pf_rnd[23:0];
         end
         jpdtc_pkg::OP_DVEL, jpdtc_pkg::OP_DRAW: begin
            // magnitude plus half the divisor, then divide
            num_ff <= QW'((diff_mul[63] ? 64'(-diff_mul) : 64'(diff_mul))
                          + 64'(dsor_ff >> 1));
            neg_ff <= diff_mul[63];
            rem_ff <= '0; quo_ff <= '0; cnt_ff <= 6'(QW);
         end
         jpdtc_pkg::OP_DIVSTEP: if (cnt_ff != 6'd0) begin
            if (rem_try >= {1'b0, dsor_ff}) begin
               rem_ff <= rem_try - {1'b0, dsor_ff}; quo_ff <= {quo_ff[QW-2:0], 1'b1};
            end else begin
               rem_ff <= rem_try; quo_ff <= {quo_ff[QW-2:0], 1'b0};
            end
            num_ff <= {num_ff[QW-2:0], 1'b0};
            cnt_ff <= cnt_ff - 6'd1;
         end
         jpdtc_pkg::OP_VEL: begin
            vel_ff <= sat32(vel_rnd); if (ovf32(vel_rnd)) clip_ff <= 1'b1;
         end
         jpdtc_pkg::OP_RV: begin
            // keep old raw velocity in vel side until filter done
            lrvold_ff <= lrvold_ff; vf_ff <= sat32(vel_rnd);
            if (ovf32(vel_rnd)) clip_ff <= 1'b1;
         end
         jpdtc_pkg::OP_VF: begin
            vf_ff <= sat32(vf_rnd); lrvold_ff <= vf_ff;
            if (ovf32(vf_rnd)) clip_ff <= 1'b1;
         end
         jpdtc_pkg::OP_PTERM:
            pd_ff2 <= 49'(pterm[63] ? -$signed(ptm) : $signed(ptm));
         jpdtc_pkg::OP_DTERM: pd_ff2 <= pd_ff2 - 49'(dterm);
         jpdtc_pkg::OP_TMUL:
            prod_ff <= (pd_ff2[48] ? 64'(-pd_ff2) : 64'(pd_ff2)) * 64'(tgr);
         jpdtc_pkg::OP_TORQ: if (pd_ff) begin
            // Saturate to 16 bits; exactly -32768 is still in range
            if (tm_rnd > 64'h7FFF) begin
               torq_ff <= pd_ff2[48] ? 16'sh8000 : 16'sh7FFF;
               if (!(pd_ff2[48] && tm_rnd == 64'h8000)) clip_ff <= 1'b1;
            end else begin
               torq_ff <= pd_ff2[48] ? -$signed(tm_rnd[15:0]) : $signed(tm_rnd[15:0]);
            end
         end
         default: ;
      endcase
   end

   // Assemble the result word
   always_ff @(posedge clock) begin
      if (in_take) begin
         oj_ff <= in_joint; ot_ff <= '0; oc_ff <= 1'b0;
         op_ff <= in_ok ? fp_ff[in_j] : '0;
         ov_ff <= in_ok ? fv_ff[in_j] : '0;
      end else if (cmd.op == jpdtc_pkg::OP_STORE) begin
         ot_ff <= torq_ff; oc_ff <= clip_ff; op_ff <= pf_ff; ov_ff <= vf_ff;
      end
   end

   assign o_joint = oj_ff; assign o_torque = ot_ff; assign o_pos = op_ff;
   assign o_vel = ov_ff; assign o_clip = oc_ff; assign o_pd = pd_ff;

   `JPD_ASSERT_NEXT(a_div_len, clock, reset,
      cmd.op == jpdtc_pkg::OP_DVEL, cnt_ff == 6'(QW))
   `JPD_ASSERT_IMPL(a_div_nz, clock, reset,
      cmd.op == jpdtc_pkg::OP_DIVSTEP, dsor_ff != '0)
   `JPD_ASSERT_NEXT(a_mode_off, clock, reset,
      in_take && in_action == jpdtc_pkg::ACT_MODE && in_cmd == jpdtc_pkg::CMD_OFF, !pd_ff)
endmodule

@@ sv/joint_pd_torque_controller_core.sv @@
// Top level of the multi-joint PD torque controller.
// Usage:
//  Words enter on req_ (valid/ready) and one result word leaves on rsp_
//  (valid/ready) for every accepted word. One word is in flight at a time.
//  Target, settings and mode words, and sample words whose joint index is
//  out of range, need no schedule: the result is valid the cycle after
//  acceptance. A sample word runs through the controller schedule: the
//  position filter, two 48-step restoring divisions for the velocities,
//  the velocity filter, the PD terms and torque scaling, then the store.
//  req_ready is high when no word is in work and the result register is
//  empty or being taken in that cycle. A stalled receiver holds rsp_ words
//  steady and the block accepts nothing new until the word is taken.
//  csr_we writes torque_gain_recip; write it only while idle.
//  Reset clears the joint state, restores default gains, home pose and
//  targets, turns PD off and sets torque_gain_recip to 65535.
`include "joint_pd_torque_controller_core_defines.svh"
module joint_pd_torque_controller_core #(
   parameter int NUM_JOINTS = jpdtc_pkg::NumJointsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [3:0]         req_joint_index,
   input  logic signed [23:0] req_raw_position,
   input  logic [15:0]        req_elapsed_us,
   input  logic signed [23:0] req_target_position,
   input  logic [15:0]        req_prop_gain_in,
   input  logic [15:0]        req_damp_gain_in,
   input  logic signed [23:0] req_home_angle_in,
   input  logic [1:0]         req_command,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_joint_out,
   output logic signed [15:0] rsp_drive_torque,
   output logic signed [23:0] rsp_smoothed_position,
   output logic signed [31:0] rsp_smoothed_velocity,
   output logic               rsp_torque_clipped,
   output logic               rsp_pd_active,
   input  logic               csr_we,
   input  logic [15:0]        csr_wdata
);
   logic [15:0] tgr_ff;
   logic rv_ff, rv_in, take, busy, done;
   jpdtc_pkg::cmd_type cmd;
   jpdtc_pkg::status_type status;

   assign req_ready = !busy && (!rv_ff || rsp_ready);
   assign take = req_valid && req_ready;

   // Hold the gain register
   always_ff @(posedge clock) begin
      if (reset) tgr_ff <= jpdtc_pkg::TGR_RESET;
      else if (csr_we) tgr_ff <= csr_wdata;
   end

   // Raise result valid when a word finishes, drop it when taken
   always_comb begin
      rv_in = rv_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      if (take && (req_action != jpdtc_pkg::ACT_SAMPLE ||
          {3'b0, req_joint_index} >= 7'(NUM_JOINTS))) rv_in = 1'b1;
      if (done) rv_in = 1'b1;
   end
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else rv_ff <= rv_in;
   end
   assign rsp_valid = rv_ff;

   jpdtc_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .start(take && req_action == jpdtc_pkg::ACT_SAMPLE &&
             {3'b0, req_joint_index} < 7'(NUM_JOINTS)),
      .status(status), .cmd(cmd), .busy(busy), .done(done)
   );

   jpdtc_datapath #(.NUM_JOINTS(NUM_JOINTS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .in_take(take), .in_action(req_action), .in_joint(req_joint_index),
      .in_raw(req_raw_position), .in_dt(req_elapsed_us),
      .in_target(req_target_position), .in_kp(req_prop_gain_in),
      .in_kd(req_damp_gain_in), .in_home(req_home_angle_in),
      .in_cmd(req_command), .tgr(tgr_ff),
      .o_joint(rsp_joint_out), .o_torque(rsp_drive_torque),
      .o_pos(rsp_smoothed_position), .o_vel(rsp_smoothed_velocity),
      .o_clip(rsp_torque_clipped), .o_pd(rsp_pd_active)
   );

   `JPD_ASSERT_IMPL(a_no_take_busy, clock, reset, busy, !req_ready)
   `JPD_ASSERT_NEXT(a_done_valid, clock, reset, done, rsp_valid)
   `JPD_ASSERT_IMPL(a_busy_novalid, clock, reset, busy, !rsp_valid)
endmodule
